// File: hw/rtl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared constants and controller/datapath interface types of the
// lexicographic permutation generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  // Default and fixed field widths.
  localparam int unsigned MaxNDefault = 8;
  localparam int unsigned ElemW       = 4;
  localparam int unsigned SizeW       = 4;
  localparam int unsigned ArrW        = 32;
  localparam int unsigned RankW       = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an item is taken this cycle
    logic emit;    // capture the current arrangement into the output register
    logic wrap;    // last arrangement was emitted: reload ascending order
    logic swap;    // swap pivot with its successor and open the suffix window
    logic step;    // swap the two ends of the suffix window and narrow it
  } lpg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_row;  // current arrangement is descending
    logic rev_more;  // suffix window still holds two or more positions
  } lpg_status_t;

endpackage

// File: hw/rtl/lpg_datapath.sv
// ----------------------------------------------------------------------------
// lpg_datapath
// Holds the current arrangement, the row counter and the output register,
// and performs pivot search, swap and one suffix swap per step.
// ----------------------------------------------------------------------------
module lpg_datapath import lpg_pkg::*; #(
  parameter int unsigned MaxN = MaxNDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  input  logic             restart_i,
  input  lpg_cmd_t         cmd_i,
  output lpg_status_t      status_o,
  output logic [ArrW-1:0]  arrangement_o,
  output logic [RankW-1:0] row_index_o,
  output logic             final_row_o
);

  localparam int unsigned IdxW = (MaxN > 1) ? $clog2(MaxN) : 1;
  localparam int unsigned NW   = $clog2(MaxN + 1);

  // Clamp a size register value to the range 1..MaxN.
  function automatic logic [NW-1:0] live_count(input logic [SizeW-1:0] size);
    logic [NW-1:0] n;
    if (size == '0) begin
      n = NW'(1);
    end else if (size > SizeW'(MaxN)) begin
      n = NW'(MaxN);
    end else begin
      n = NW'(size);
    end
    return n;
  endfunction

  logic [SizeW-1:0] size_q, size_d;
  logic [ElemW-1:0] ord_q [MaxN];
  logic [ElemW-1:0] ord_d [MaxN];
  logic [RankW-1:0] rank_q, rank_d;
  logic [IdxW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [ArrW-1:0]  arr_q, arr_d;
  logic [RankW-1:0] row_q;
  logic             fin_q;

  logic [NW-1:0]    n_live, n_load;
  logic             piv_found;
  logic [IdxW-1:0]  piv_idx, succ_idx;
  logic [ElemW-1:0] piv_val;
  logic             reload;

  assign n_live = live_count(size_q);

  // Rightmost position whose value is smaller than its right neighbor.
  always_comb begin
    piv_found = 1'b0;
    piv_idx   = '0;
    for (int k = 0; k + 1 < MaxN; k++) begin
      if ((NW'(k + 1) < n_live) && (ord_q[k] < ord_q[k + 1])) begin
        piv_found = 1'b1;
        piv_idx   = IdxW'(k);
      end
    end
  end

  assign piv_val = ord_q[piv_idx];

  // Rightmost position past the pivot holding a larger value.
  always_comb begin
    succ_idx = '0;
    for (int j = 0; j < MaxN; j++) begin
      if ((NW'(j) < n_live) && (IdxW'(j) > piv_idx) && (ord_q[j] > piv_val)) begin
        succ_idx = IdxW'(j);
      end
    end
  end

  always_comb begin
    arr_d = '0;
    for (int k = 0; k < MaxN; k++) begin
      arr_d[k*ElemW +: ElemW] = ord_q[k];
    end
  end

  assign reload = (cmd_i.accept && restart_i) || cmd_i.wrap;
  assign n_load = cfg_we_i ? live_count(cfg_wdata_i) : n_live;

  always_comb begin
    size_d = size_q;
    ord_d  = ord_q;
    rank_d = rank_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    if (cfg_we_i) begin
      size_d = cfg_wdata_i;
    end
    if (cfg_we_i || reload) begin
      for (int k = 0; k < MaxN; k++) begin
        ord_d[k] = (NW'(k) < n_load) ? ElemW'(k + 1) : '0;
      end
      rank_d = '0;
    end else if (cmd_i.swap) begin
      ord_d[piv_idx]  = ord_q[succ_idx];
      ord_d[succ_idx] = piv_val;
      lo_d   = piv_idx + IdxW'(1);
      hi_d   = IdxW'(n_live - NW'(1));
      rank_d = rank_q + RankW'(1);
    end else if (cmd_i.step) begin
      ord_d[lo_q] = ord_q[hi_q];
      ord_d[hi_q] = ord_q[lo_q];
      lo_d = lo_q + IdxW'(1);
      hi_d = hi_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(4);
      rank_q <= '0;
      for (int k = 0; k < MaxN; k++) begin
        ord_q[k] <= (k < 4) ? ElemW'(k + 1) : '0;
      end
    end else begin
      size_q <= size_d;
      rank_q <= rank_d;
      ord_q  <= ord_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.emit) begin
      arr_q <= arr_d;
      row_q <= rank_q;
      fin_q <= !piv_found;
    end
  end

  assign status_o.last_row = !piv_found;
  assign status_o.rev_more = lo_q < hi_q;
  assign arrangement_o     = arr_q;
  assign row_index_o       = row_q;
  assign final_row_o       = fin_q;

endmodule

// File: hw/rtl/lpg_controller.sv
// ----------------------------------------------------------------------------
// lpg_controller
// Sequences one item: accept, emit into the output register, then advance
// the arrangement through swap and suffix reversal steps or a wrap.
// ----------------------------------------------------------------------------
module lpg_controller import lpg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  lpg_status_t status_i,
  output lpg_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEmit = 2'd1;
  localparam logic [1:0] StRev  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_row) begin
            cmd_o.wrap = 1'b1;
            state_d    = StIdle;
          end else begin
            cmd_o.swap = 1'b1;
            state_d    = StRev;
          end
        end
      end
      StRev: begin
        if (status_i.rev_more) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/lexicographic_permutation_generator.sv
// ----------------------------------------------------------------------------
// lexicographic_permutation_generator
// Emits the permutations of 1..n in lexicographic order, one per item.
// ----------------------------------------------------------------------------
// Usage:
//   Each item taken on the input channel (in_valid_i/in_ready_o) requests one
//   permutation. With restart_i set, the sequence first returns to ascending
//   order and row 0. The result item carries the arrangement (four bits per
//   position, unused positions zero), its row number and a flag that marks
//   the final, descending arrangement; after that one the sequence wraps.
//   The size n is written through cfg_we_i/cfg_wdata_i while the block is
//   idle; a write reloads ascending order and clears the row counter.
//   Sequence: once an item is accepted, the controller waits in its emit
//   state until the output register is free, then captures the arrangement
//   and, in the same cycle, swaps the pivot with its successor; the reversal
//   state then swaps one pair of the reversed suffix per cycle and returns
//   to idle. After the final, descending arrangement it reloads ascending
//   order instead and goes straight to idle; only in idle is an item taken.
//   When the receiver stalls, the result waits in the output register and
//   the block waits with it before emitting the next one. Reset gives n = 4,
//   ascending order and row 0.
// ----------------------------------------------------------------------------
module lexicographic_permutation_generator import lpg_pkg::*; #(
  parameter int unsigned MaxN = MaxNDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ArrW-1:0]  arrangement_o,
  output logic [RankW-1:0] row_index_o,
  output logic             final_row_o
);

  lpg_cmd_t    cmd;
  lpg_status_t status;

  // The controller only sequences; all arrangement state lives in the datapath.
  lpg_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lpg_datapath #(
    .MaxN (MaxN)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .restart_i     (restart_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .arrangement_o (arrangement_o),
    .row_index_o   (row_index_o),
    .final_row_o   (final_row_o)
  );

endmodule

// File: hw/rtl/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks of the permutation generator, bound to the top level.
// ----------------------------------------------------------------------------
module lpg_checker import lpg_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ArrW-1:0]  arrangement_o,
  input logic [RankW-1:0] row_index_o,
  input logic             final_row_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(arrangement_o) && $stable(row_index_o) &&
      $stable(final_row_o))
    else $error("stalled result changed");

  // One item at a time: no second item right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // The first position always holds a live element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> arrangement_o[3:0] != 4'd0)
    else $error("empty first position");

  // Row zero is the ascending arrangement, which starts with one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (row_index_o == '0) |-> arrangement_o[3:0] == 4'd1)
    else $error("row zero is not ascending");

endmodule

bind lexicographic_permutation_generator lpg_checker u_lpg_checker (.*);

// File: sim/tb_lexicographic_permutation_generator.sv
// ----------------------------------------------------------------------------
// tb_lexicographic_permutation_generator
// Self-checking testbench for the lexicographic permutation generator. A
// directed table covers reset state, size extremes, clamping, restart and
// wrap. A long random run then walks many sizes with random handshake gaps on
// both channels. Every result item is compared with a local permutation
// predictor that keeps its own copy of the arrangement and row counter.
// ----------------------------------------------------------------------------
module tb_lexicographic_permutation_generator;
  import lpg_pkg::*;

  // One result item as the block emits it.
  typedef struct packed {
    logic [ArrW-1:0]  arr;
    logic [RankW-1:0] row;
    logic             fin;
  } perm_result_t;

  // A directed row either writes the size register or requests one item.
  typedef enum logic {
    OpRequest,
    OpSetSize
  } plan_op_e;

  typedef struct {
    plan_op_e     op;
    logic [3:0]   val;    // restart bit for a request, size for a write
    bit           typed;  // expected result spelled out below
    perm_result_t want;
  } plan_row_t;

  localparam int PlanLen = 31;

  // Expected results that are written out are those that can be read at a
  // glance: reset state, single element, clamped sizes and the wrap points.
  // Every other request is checked against the predictor.
  plan_row_t plan [PlanLen] = '{
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_4321, 16'd0, 1'b0}},  // reset: n = 4
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_3421, 16'd1, 1'b0}},
    '{OpRequest, 4'd1,  1'b1, '{32'h0000_4321, 16'd0, 1'b0}},  // restart
    '{OpSetSize, 4'd1,  1'b0, '0},                             // single element
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_0001, 16'd0, 1'b1}},
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_0001, 16'd0, 1'b1}},
    '{OpSetSize, 4'd0,  1'b0, '0},                             // size zero
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_0001, 16'd0, 1'b1}},
    '{OpRequest, 4'd1,  1'b1, '{32'h0000_0001, 16'd0, 1'b1}},
    '{OpSetSize, 4'd15, 1'b0, '0},                             // clamps to 8
    '{OpRequest, 4'd0,  1'b1, '{32'h8765_4321, 16'd0, 1'b0}},
    '{OpRequest, 4'd0,  1'b1, '{32'h7865_4321, 16'd1, 1'b0}},
    '{OpSetSize, 4'd9,  1'b0, '0},                             // clamps to 8
    '{OpRequest, 4'd0,  1'b1, '{32'h8765_4321, 16'd0, 1'b0}},
    '{OpSetSize, 4'd2,  1'b0, '0},
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_0021, 16'd0, 1'b0}},
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_0012, 16'd1, 1'b1}},
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_0021, 16'd0, 1'b0}},  // wrapped
    '{OpRequest, 4'd1,  1'b1, '{32'h0000_0021, 16'd0, 1'b0}},
    '{OpSetSize, 4'd3,  1'b0, '0},
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_0321, 16'd0, 1'b0}},
    '{OpRequest, 4'd0,  1'b0, '0},
    '{OpRequest, 4'd0,  1'b0, '0},
    '{OpRequest, 4'd0,  1'b0, '0},
    '{OpRequest, 4'd0,  1'b0, '0},
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_0123, 16'd5, 1'b1}},  // descending
    '{OpRequest, 4'd0,  1'b1, '{32'h0000_0321, 16'd0, 1'b0}},  // wrapped
    '{OpSetSize, 4'd8,  1'b0, '0},
    '{OpRequest, 4'd1,  1'b0, '0},
    '{OpRequest, 4'd0,  1'b0, '0},
    '{OpRequest, 4'd0,  1'b0, '0}
  };

  // Sizes visited by the random phases; the last phase picks one at random.
  localparam int PhaseCount     = 11;
  localparam int ItemsPerPhase  = 72;
  localparam logic [SizeW-1:0] PhaseSize [PhaseCount-1] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd15
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [SizeW-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             restart_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ArrW-1:0]  arrangement_o;
  logic [RankW-1:0] row_index_o;
  logic             final_row_o;

  // Predictor state: the size register, the arrangement and the row counter.
  logic [SizeW-1:0] model_size;
  logic [ElemW-1:0] model_order [MaxNDefault];
  logic [RankW-1:0] model_rank;

  perm_result_t expected_perms [$];

  int  mismatch_count;
  int  request_count;
  int  size_write_count;
  int  result_count;
  int  final_count;
  bit  calm;  // when set, neither side inserts idle cycles

  lexicographic_permutation_generator #(
    .MaxN(MaxNDefault)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .arrangement_o(arrangement_o),
    .row_index_o  (row_index_o),
    .final_row_o  (final_row_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // A size of zero acts as one element; anything above the maximum is clamped.
  function automatic int live_size();
    if (model_size == '0) begin
      return 1;
    end
    if (int'(model_size) > MaxNDefault) begin
      return MaxNDefault;
    end
    return int'(model_size);
  endfunction

  task automatic load_ascending();
    int n;
    n = live_size();
    for (int k = 0; k < MaxNDefault; k++) begin
      model_order[k] = (k < n) ? ElemW'(k + 1) : '0;
    end
    model_rank = '0;
  endtask

  // Emits the current arrangement and then steps to its lexicographic
  // successor: find the rightmost ascent, swap its left element with the
  // rightmost larger value after it, then reverse everything past the ascent.
  task automatic predict_step(input logic restart, output perm_result_t res);
    int n;
    int piv;
    int s;
    int lo;
    int hi;
    logic [ElemW-1:0] t;
    n = live_size();
    if (restart) begin
      load_ascending();
    end
    res.arr = '0;
    for (int k = 0; k < n; k++) begin
      res.arr[ElemW*k +: ElemW] = model_order[k];
    end
    piv = -1;
    for (int k = 0; k + 1 < n; k++) begin
      if (model_order[k] < model_order[k+1]) begin
        piv = k;
      end
    end
    res.row = model_rank;
    res.fin = (piv < 0);
    if (piv < 0) begin
      // The descending arrangement was emitted, so the sequence wraps.
      load_ascending();
    end else begin
      s = n - 1;
      while (model_order[s] <= model_order[piv]) begin
        s--;
      end
      t = model_order[piv];
      model_order[piv] = model_order[s];
      model_order[s] = t;
      lo = piv + 1;
      hi = n - 1;
      while (lo < hi) begin
        t = model_order[lo];
        model_order[lo] = model_order[hi];
        model_order[hi] = t;
        lo++;
        hi--;
      end
      model_rank = model_rank + 1'b1;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Offers one request item. The valid stays high from the previous item when
  // no gap is drawn, so it never sees a low and a high in the same step.
  task automatic request_perm(input logic restart, input bit typed,
                              input perm_result_t want);
    int gap;
    perm_result_t predicted;
    gap = calm ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    // The item was taken at this edge; the predictor advances in step.
    predict_step(restart, predicted);
    expected_perms.push_back(typed ? want : predicted);
    request_count++;
  endtask

  // Lowers the request valid and waits until every result is back, then lets
  // the block finish advancing its arrangement.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_perms.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [SizeW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    // Any size write restarts the sequence at ascending order and row 0.
    model_size = value;
    load_ascending();
    size_write_count++;
  endtask

  // Result side: draws a stall before each item, then takes whatever comes.
  initial begin
    int stall;
    perm_result_t want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      result_count++;
      if (final_row_o) begin
        final_count++;
      end
      if (expected_perms.size() == 0) begin
        flag_mismatch($sformatf("unexpected result arr=%h row=%0d final=%b",
                                arrangement_o, row_index_o, final_row_o));
      end else begin
        want = expected_perms.pop_front();
        if (arrangement_o !== want.arr) begin
          flag_mismatch($sformatf("arrangement %h, expected %h", arrangement_o,
                                  want.arr));
        end
        if (row_index_o !== want.row) begin
          flag_mismatch($sformatf("row_index %0d, expected %0d (arr %h)",
                                  row_index_o, want.row, want.arr));
        end
        if (final_row_o !== want.fin) begin
          flag_mismatch($sformatf("final_row %b, expected %b (arr %h)",
                                  final_row_o, want.fin, want.arr));
        end
      end
    end
  end

  // Stimulus and the end of the run.
  initial begin
    logic [SizeW-1:0] phase_size;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    restart_i        = 1'b0;
    calm             = 1'b0;
    mismatch_count   = 0;
    request_count    = 0;
    size_write_count = 0;
    result_count     = 0;
    final_count      = 0;
    model_size       = SizeW'(4);
    load_ascending();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    for (int i = 0; i < PlanLen; i++) begin
      if (plan[i].op == OpSetSize) begin
        write_size(plan[i].val);
      end else begin
        request_perm(plan[i].val[0], plan[i].typed, plan[i].want);
      end
    end

    // Random part. Most items continue the running sequence so that small
    // sizes wrap many times over; a rare restart breaks a sequence midway.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      phase_size = (ph < PhaseCount - 1) ? PhaseSize[ph]
                                         : SizeW'($urandom_range(0, 15));
      write_size(phase_size);
      calm = (ph % 3 == 2);
      for (int j = 0; j < ItemsPerPhase; j++) begin
        if (ph == 5 && j == ItemsPerPhase / 2) begin
          // Let the block run completely dry in the middle of a sequence.
          drain_results();
        end
        request_perm($urandom_range(0, 39) == 0, 1'b0, '0);
      end
    end

    calm = 1'b0;
    drain_results();
    if (expected_perms.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", expected_perms.size()));
    end
    $display("Run covered %0d requests over %0d size writes; %0d results checked.",
             request_count, size_write_count, result_count);
    $display("Descending arrangements seen with their wrap: %0d.", final_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: lexicographic_permutation_generator.f
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_datapath.sv
hw/rtl/lpg_controller.sv
hw/rtl/lexicographic_permutation_generator.sv
hw/rtl/lpg_checker.sv
sim/tb_lexicographic_permutation_generator.sv
